// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the bucket table RTL.
// Included by every file that carries concurrent checks; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KV_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("kvbt assertion failed");
`define KV_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("kvbt implication failed");
`define KV_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("kvbt next-cycle check failed");
`else
`define KV_ASSERT(lbl, clk, rst_n, expr)
`define KV_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define KV_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/kvbt_pkg.sv -----
// Package for the key/value bucket table: widths, request and status codes,
// and the command word passed from the front queue to the back end. No dependencies.
package kvbt_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned KEY_W         = 32;
	localparam int unsigned VAL_W         = 32;
	localparam int unsigned REQ_W         = 2;
	localparam int unsigned STATUS_W      = 2;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT     = 2'd0,
		REQ_LOOKUP     = 2'd1,
		REQ_LOOKUP_ALL = 2'd2,
		REQ_REMOVE     = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		req_t             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage

// ----- rtl/core/kvbt_req_if.sv -----
// Request channel: valid/ready handshake carrying one request transaction.
// Depends on kvbt_pkg for field widths.
interface kvbt_req_if import kvbt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

// ----- rtl/core/kvbt_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result transaction.
// Depends on kvbt_pkg for field widths.
interface kvbt_rsp_if import kvbt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    value_out;
	logic                last;

	modport source (output valid, output status, output value_out, output last, input ready);
	modport sink   (input valid, input status, input value_out, input last, output ready);
endinterface

// ----- rtl/core/kvbt_front.sv -----
// Front end: accepts request transactions, decodes the request code and
// buffers commands in a short queue for the back end. Depends on kvbt_pkg, kvbt_req_if.
module kvbt_front import kvbt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kvbt_req_if.sink   req,
	output logic       head_valid,
	output cmd_t       head_cmd,
	input  logic       head_pop
);

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	logic              pop;
	cmd_t              in_cmd;

	always_comb begin
		in_cmd.op    = req_t'(req.req_type);
		in_cmd.key   = req.key;
		in_cmd.value = req.value;
	end

	assign req.ready  = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = req.valid && req.ready;
	assign head_valid = (fill_q != '0);
	assign pop        = head_pop && head_valid;
	assign head_cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/kvbt_back.sv -----
// Back end: ordered key/value store with parallel key match, a two-state
// sequencer and the registered result stage. Depends on kvbt_pkg, kvbt_rsp_if, assert_macros.svh.
`include "assert_macros.svh"
module kvbt_back import kvbt_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       head_pop,
	kvbt_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DEPTH);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t            state_q;
	logic [KEY_W-1:0]  key_q   [DEPTH];
	logic [VAL_W-1:0]  value_q [DEPTH];
	logic [CNT_W-1:0]  count_q;
	cmd_t              cmd_q;
	logic [DEPTH-1:0]  hits_q;
	logic              rsp_valid_q;
	status_t           status_q;
	logic [VAL_W-1:0]  value_out_q;
	logic              last_q;

	logic [DEPTH-1:0]  hit_now;
	logic [DEPTH-1:0]  low;
	logic [DEPTH-1:0]  below;
	logic [DEPTH-1:0]  rest;
	logic [VAL_W-1:0]  sel_value;
	logic              any_hit;
	logic              full;
	logic              out_free;
	logic              emit;
	logic              do_insert;
	logic              do_remove;
	status_t           res_status;
	logic [VAL_W-1:0]  res_value;
	logic              res_last;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_now[i] = (CNT_W'(i) < count_q) && (key_q[i] == head_cmd.key);
		end
	end

	assign low     = hits_q & (~hits_q + DEPTH'(1));
	assign below   = low - DEPTH'(1);
	assign rest    = hits_q & ~low;
	assign any_hit = |hits_q;
	assign full    = (count_q == CNT_W'(DEPTH));

	always_comb begin
		sel_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_value = sel_value | ({VAL_W{low[i]}} & value_q[i]);
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_value  = '0;
		res_last   = 1'b1;
		unique case (cmd_q.op) inside
			REQ_INSERT: begin
				res_status = full ? ST_FULL : ST_OK;
			end
			REQ_LOOKUP, REQ_REMOVE: begin
				res_status = any_hit ? ST_OK : ST_MISS;
				res_value  = any_hit ? sel_value : '0;
			end
			REQ_LOOKUP_ALL: begin
				res_status = any_hit ? ST_OK : ST_MISS;
				res_value  = any_hit ? sel_value : '0;
				res_last   = (rest == '0);
			end
			default: begin
				res_status = ST_MISS;
			end
		endcase
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign emit      = (state_q == S_EXEC) && out_free;
	assign do_insert = emit && (cmd_q.op == REQ_INSERT) && !full;
	assign do_remove = emit && (cmd_q.op == REQ_REMOVE) && any_hit;
	assign head_pop  = (state_q == S_IDLE) && head_valid;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.value_out = value_out_q;
	assign rsp.last      = last_q;

	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_q[count_q[IDX_W-1:0]]   <= cmd_q.key;
			value_q[count_q[IDX_W-1:0]] <= cmd_q.value;
		end
		if (do_remove) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (!below[i]) begin
					key_q[i]   <= key_q[i + 1];
					value_q[i] <= value_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cmd_q       <= '0;
			hits_q      <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_OK;
			value_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !emit) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						cmd_q   <= head_cmd;
						hits_q  <= hit_now;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status;
						value_out_q <= res_value;
						last_q      <= res_last;
						hits_q      <= rest;
						if (do_insert) begin
							count_q <= count_q + CNT_W'(1);
						end else if (do_remove) begin
							count_q <= count_q - CNT_W'(1);
						end
						if (res_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`KV_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`KV_ASSERT_NEXT(a_insert_grows, clk, arst_n, do_insert, count_q == $past(count_q) + CNT_W'(1))
	`KV_ASSERT_NEXT(a_remove_shrinks, clk, arst_n, do_remove, count_q == $past(count_q) - CNT_W'(1))
	`KV_ASSERT_IMPL(a_full_only_at_depth, clk, arst_n, emit && (res_status == ST_FULL), full && (cmd_q.op == REQ_INSERT))
	`KV_ASSERT_NEXT(a_all_drops_one, clk, arst_n, emit && (cmd_q.op == REQ_LOOKUP_ALL) && !res_last, $countones(hits_q) == $countones($past(hits_q)) - 1)

endmodule

// ----- rtl/core/key_value_bucket_table_core.sv -----
// Top level of the key/value bucket table: request queue front end and store back end.
// Depends on kvbt_pkg, kvbt_req_if, kvbt_rsp_if, kvbt_front, kvbt_back.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type[1:0], key[31:0], value[31:0]
//   rsp      out  valid/ready   status[1:0], value_out[31:0], last
//
// In the back end, the idle state registers the key match against every held entry,
// then the execute state executes and loads the result register. Lookup-all returns
// one result per hit, or a single miss. A two-entry queue takes requests while the
// back end is busy. Reset empties the store and the queue at once; no clearing pass.
// A stalled rsp holds the back end; req stalls only when the queue is full.
module key_value_bucket_table_core import kvbt_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	kvbt_req_if.sink   req,
	kvbt_rsp_if.source rsp
);

	logic head_valid;
	cmd_t head_cmd;
	logic head_pop;

	kvbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.head_pop   (head_pop)
	);

	kvbt_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.head_pop   (head_pop),
		.rsp        (rsp)
	);

endmodule
